[design/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, types and helper functions of the UV sphere tile generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   // default count limits
   localparam int MAX_STACKS_DEF = 256;
   localparam int MAX_SLICES_DEF = 256;

   // register indexes of the csr port
   localparam logic CSR_STACK_COUNT = 1'b0;
   localparam logic CSR_SLICE_COUNT = 1'b1;

   // reset value of both count registers
   localparam logic [8:0] COUNT_RESET = 9'd16;
   localparam logic [8:0] COUNT_MIN   = 9'd2;

   // restoring divider: 11 integer steps of 4n plus 30 fraction steps
   localparam int N4_W      = 11;
   localparam int FRAC_W    = 30;
   localparam int DIV_STEPS = N4_W + FRAC_W;
   // sine/cosine unit latency: divider, square, four horner steps, final
   // multiply, quadrant mapping
   localparam int SC_LATENCY = DIV_STEPS + 7;

   // one in unsigned q1.30
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // taylor coefficients of sin(pi/2 u) in q1.30, highest power first
   localparam logic [30:0] TAY_COEF [5] = '{
      31'd172273, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   // vertex emit order
   localparam logic [2:0] LAST_SLOT = 3'd5;

   typedef logic [30:0] q30_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } vert_type;

   // product of two q30 values, truncated by 30 bits
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic [61:0] prod;
      begin
         prod = 62'(a) * 62'(b);
         return prod[60:30];
      end
   endfunction

   // round to nearest, ties away from zero, by 46 bits
   function automatic logic signed [15:0] round_q46(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] t;
      logic [15:0] q;
      begin
         m = v[63] ? 64'(-v) : 64'(v);
         t = m + (64'd1 << 45);
         q = t[61:46];
         return v[63] ? 16'(-q) : q;
      end
   endfunction

   // round to nearest, ties away from zero, by 16 bits
   function automatic logic signed [15:0] round_q16(input logic signed [31:0] v);
      logic [31:0] m;
      logic [31:0] t;
      logic [15:0] q;
      begin
         m = v[31] ? 32'(-v) : 32'(v);
         t = m + (32'd1 << 15);
         q = t[31:16];
         return v[31] ? 16'(-q) : q;
      end
   endfunction

   // doubled value saturated to 16 bits
   function automatic logic signed [15:0] twice_sat(input logic signed [15:0] v);
      logic signed [16:0] t;
      begin
         t = {v, 1'b0};
         if (t > 17'sd32767) begin
            return 16'sh7fff;
         end else if (t < -17'sd32768) begin
            return 16'sh8000;
         end
         return t[15:0];
      end
   endfunction

   // corner shown at each slot of the run
   function automatic logic [1:0] corner_of_slot(input logic [2:0] slot);
      case (slot)
         3'd0: return 2'd0;
         3'd1: return 2'd2;
         3'd2: return 2'd3;
         3'd3: return 2'd0;
         3'd4: return 2'd3;
         3'd5: return 2'd1;
         default: return 2'd0;
      endcase
   endfunction

endpackage

[design/uvs_req_if.sv]
// ----------------------------------------------------------------------------
// uvs_req_if
// Tile request channel: stack and slice index with valid/ready.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stack_index;
   logic [7:0] slice_index;

   modport source (output valid, stack_index, slice_index, input ready);
   modport sink   (input valid, stack_index, slice_index, output ready);
endinterface

[design/uvs_rsp_if.sv]
// ----------------------------------------------------------------------------
// uvs_rsp_if
// Vertex result channel: position, normal and run position with valid/ready.
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [2:0]         corner_slot;
   logic               last_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   corner_slot, last_vertex, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   corner_slot, last_vertex, output ready);
endinterface

[design/uvs_sincos.sv]
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine and cosine of n/d turn: restoring divider one bit per stage,
// then a horner polynomial for both quarter-wave values, then quadrant mapping.
// ----------------------------------------------------------------------------
module uvs_sincos (
   input  logic               clock,
   input  logic               enable,
   input  logic [8:0]         num_in,
   input  logic [9:0]         den_in,
   output logic signed [31:0] sin_out,
   output logic signed [31:0] cos_out
);
   import uvs_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   logic [9:0]      rem_ff [DIV_STEPS];
   logic [N4_W-1:0] num_ff [DIV_STEPS];
   logic [9:0]      den_ff [DIV_STEPS];
   logic [31:0]     quo_ff [DIV_STEPS];

   // divider chain: quotient of 4n * 2^30 / d
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [9:0]      rem_prev;
      logic [N4_W-1:0] num_prev;
      logic [9:0]      den_prev;
      logic [31:0]     quo_prev;
      logic            nbit;
      logic [10:0]     shl;
      logic            ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = {num_in, 2'b00};
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      if (k < N4_W) begin : g_int
         assign nbit = num_prev[N4_W-1-k];
      end else begin : g_frac
         assign nbit = 1'b0;
      end

      assign shl = {rem_prev, nbit};
      assign ge  = shl >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? 10'(shl - {1'b0, den_prev}) : shl[9:0];
            num_ff[k] <= num_prev;
            den_ff[k] <= den_prev;
            quo_ff[k] <= {quo_prev[30:0], ge};
         end
      end
   end

   // quarter-wave arguments u and 1 - u
   q30_type arg_in [2];
   assign arg_in[0] = {1'b0, quo_ff[DIV_STEPS-1][FRAC_W-1:0]};
   assign arg_in[1] = Q30_ONE - {1'b0, quo_ff[DIV_STEPS-1][FRAC_W-1:0]};

   q30_type    arg_ff [2][5];
   q30_type    s_ff   [2][4];
   q30_type    p_ff   [2][4];
   q30_type    fin_ff [2];
   logic [1:0] q_ff   [6];
   q30_type    fin_in [2];

   // final multiply with clamp to one
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         fin_in[l] = mul_q30(p_ff[l][3], arg_ff[l][4]);
         if (fin_in[l] > Q30_ONE) begin
            fin_in[l] = Q30_ONE;
         end
      end
   end

   // square, horner steps and final product, one multiply per stage
   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff[0] <= quo_ff[DIV_STEPS-1][FRAC_W+1:FRAC_W];
         for (int t = 1; t < 6; t++) begin
            q_ff[t] <= q_ff[t-1];
         end
         for (int l = 0; l < 2; l++) begin
            arg_ff[l][0] <= arg_in[l];
            s_ff[l][0]   <= mul_q30(arg_in[l], arg_in[l]);
            for (int t = 1; t < 5; t++) begin
               arg_ff[l][t] <= arg_ff[l][t-1];
            end
            for (int t = 1; t < 4; t++) begin
               s_ff[l][t] <= s_ff[l][t-1];
            end
            p_ff[l][0] <= TAY_COEF[1] - mul_q30(TAY_COEF[0], s_ff[l][0]);
            for (int t = 1; t < 4; t++) begin
               p_ff[l][t] <= TAY_COEF[t+1] - mul_q30(p_ff[l][t-1], s_ff[l][t]);
            end
            fin_ff[l] <= fin_in[l];
         end
      end
   end

   // quadrant mapping
   logic signed [31:0] pa;
   logic signed [31:0] pb;
   assign pa = {1'b0, fin_ff[0]};
   assign pb = {1'b0, fin_ff[1]};

   always_ff @(posedge clock) begin
      if (enable) begin
         case (q_ff[5])
            QUAD_0: begin
               sin_out <= pa;
               cos_out <= pb;
            end
            QUAD_1: begin
               sin_out <= pb;
               cos_out <= -pa;
            end
            QUAD_2: begin
               sin_out <= -pa;
               cos_out <= -pb;
            end
            QUAD_3: begin
               sin_out <= -pb;
               cos_out <= pa;
            end
            default: begin
               sin_out <= pa;
               cos_out <= pb;
            end
         endcase
      end
   end

endmodule

[design/uvs_emit.sv]
// ----------------------------------------------------------------------------
// uvs_emit
// Output stage: holds the four corners of one tile and sends the six vertices
// of its two triangles, one per transaction.
// ----------------------------------------------------------------------------
module uvs_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_valid,
   input  uvs_pkg::vert_type [3:0]   load_corners,
   output logic                      take,
   uvs_rsp_if.source                 rsp_chan
);
   import uvs_pkg::*;

   logic            busy_ff;
   logic [2:0]      slot_ff;
   vert_type [3:0]  corners_ff;
   logic            fire;
   vert_type        cur;

   assign fire = rsp_chan.valid && rsp_chan.ready;
   assign take = !busy_ff || (fire && (slot_ff == LAST_SLOT));

   // run control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= '0;
      end else if (load_valid && take) begin
         busy_ff <= 1'b1;
         slot_ff <= '0;
      end else if (fire) begin
         if (slot_ff == LAST_SLOT) begin
            busy_ff <= 1'b0;
         end else begin
            slot_ff <= slot_ff + 3'd1;
         end
      end
   end

   // corner store
   always_ff @(posedge clock) begin
      if (load_valid && take) begin
         corners_ff <= load_corners;
      end
   end

   // vertex select
   assign cur                  = corners_ff[corner_of_slot(slot_ff)];
   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.pos_x       = cur.x;
   assign rsp_chan.pos_y       = cur.y;
   assign rsp_chan.pos_z       = cur.z;
   assign rsp_chan.norm_x      = twice_sat(cur.x);
   assign rsp_chan.norm_y      = twice_sat(cur.y);
   assign rsp_chan.norm_z      = twice_sat(cur.z);
   assign rsp_chan.corner_slot = slot_ff;
   assign rsp_chan.last_vertex = slot_ff == LAST_SLOT;

endmodule

[design/uv_sphere_tile_generator.sv]
// ----------------------------------------------------------------------------
// uv_sphere_tile_generator
// One tile of a UV sphere of radius 0.5 per request, six vertices out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries a tile (stack_index, slice_index). rsp_chan returns six
//   vertices, v0 v2 v3 v0 v3 v1, each with position and normal in q1.15,
//   corner_slot 0..5 and last_vertex on the sixth.
//   csr_we/csr_index/csr_wdata set stack_count and slice_count; write them
//   only while no tile is in flight.
//   A request passes the pipeline stages below, then the output stage
//   registers its tile before the first vertex is valid.
//   Throughput: one vertex per cycle while rsp_chan.ready is high; requests
//   enter a 51-stage pipeline (input stage, 41 divider steps, 7 sine/cosine
//   steps, products and rounding) while the previous tile drains.
//   Reset: both counts return to 16, pipeline and output empty.
//   Stall: the pipeline holds only while its last stage holds a tile the
//   output stage cannot take; req_chan.ready is low exactly then.
// ----------------------------------------------------------------------------
module uv_sphere_tile_generator #(
   parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF,
   parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   uvs_req_if.sink     req_chan,
   uvs_rsp_if.source   rsp_chan
);
   import uvs_pkg::*;

   localparam int PIPE_LEN = SC_LATENCY + 3;

   logic [8:0] stack_count_ff;
   logic [8:0] slice_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= COUNT_RESET;
         slice_count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STACK_COUNT: stack_count_ff <= csr_wdata;
            CSR_SLICE_COUNT: slice_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective counts
   logic [8:0] eff_stacks;
   logic [8:0] eff_slices;
   always_comb begin
      eff_stacks = stack_count_ff;
      if (stack_count_ff < COUNT_MIN) begin
         eff_stacks = COUNT_MIN;
      end else if ({4'b0, stack_count_ff} > 13'(MAX_STACKS)) begin
         eff_stacks = 9'(MAX_STACKS);
      end
      eff_slices = slice_count_ff;
      if (slice_count_ff < COUNT_MIN) begin
         eff_slices = COUNT_MIN;
      end else if ({4'b0, slice_count_ff} > 13'(MAX_SLICES)) begin
         eff_slices = 9'(MAX_SLICES);
      end
   end

   logic          adv;
   logic          take;
   logic [PIPE_LEN-1:0] vld_ff;

   assign adv            = !vld_ff[PIPE_LEN-1] || take;
   assign req_chan.ready = adv;

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], req_chan.valid};
      end
   end

   // input stage
   logic [7:0] i_ff;
   logic [7:0] j_ff;
   logic [9:0] ds_ff;
   logic [9:0] dl_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         i_ff  <= req_chan.stack_index;
         j_ff  <= req_chan.slice_index;
         ds_ff <= {eff_stacks, 1'b0};
         dl_ff <= {1'b0, eff_slices};
      end
   end

   // angle units: phi at i and i+1, theta at j and j+1
   logic signed [31:0] sp [2];
   logic signed [31:0] cp [2];
   logic signed [31:0] st [2];
   logic signed [31:0] ct [2];

   for (genvar a = 0; a < 2; a++) begin : g_ang
      uvs_sincos u_phi (
         .clock   (clock),
         .enable  (adv),
         .num_in  ({1'b0, i_ff} + 9'(a)),
         .den_in  (ds_ff),
         .sin_out (sp[a]),
         .cos_out (cp[a])
      );
      uvs_sincos u_theta (
         .clock   (clock),
         .enable  (adv),
         .num_in  ({1'b0, j_ff} + 9'(a)),
         .den_in  (dl_ff),
         .sin_out (st[a]),
         .cos_out (ct[a])
      );
   end

   // product stage
   logic signed [63:0] px_ff [2][2];
   logic signed [63:0] pz_ff [2][2];
   logic signed [31:0] cp_ff [2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            cp_ff[a] <= cp[a];
            for (int b = 0; b < 2; b++) begin
               px_ff[a][b] <= 64'(sp[a]) * 64'(st[b]);
               pz_ff[a][b] <= 64'(sp[a]) * 64'(ct[b]);
            end
         end
      end
   end

   // rounding stage, corner index {phi step, theta step}
   vert_type [3:0] corner_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
               corner_ff[a*2+b].x <= round_q46(px_ff[a][b]);
               corner_ff[a*2+b].y <= round_q16(cp_ff[a]);
               corner_ff[a*2+b].z <= round_q46(pz_ff[a][b]);
            end
         end
      end
   end

   // vertex output
   uvs_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (vld_ff[PIPE_LEN-1]),
      .load_corners (corner_ff),
      .take         (take),
      .rsp_chan     (rsp_chan)
   );

   // a stalled pipeline keeps its finished tile
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff[PIPE_LEN-1])
      else $error("finished tile lost during stall");

   // an accepted request enters the pipeline
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted request not in first stage");

   // output position holds while the receiver stalls
   a_slot_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.corner_slot)))
      else $error("vertex changed while stalled");

endmodule
